[sv/lmfb_pkg.sv]
package lmfb_pkg;

	// default geometry and grayscale width
	localparam int ROWS_DEF      = 8;
	localparam int COLUMNS_DEF   = 16;
	localparam int GRAY_BITS_DEF = 12;

	// pixel index layout: row in the upper bits, column in the low four
	localparam int INDEX_SHIFT = 4;
	localparam int QUEUE_DEPTH = 2;

	// color limits and reset fill of the back buffer
	localparam logic [9:0] SUM_LIMIT   = 10'd255;
	localparam logic [7:0] CHANNEL_MAX = 8'd255;
	localparam logic [7:0] BACK_FILL   = 8'd63;

	// request and result codes
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_SCAN  = 1'b1;
	localparam logic KIND_ACK  = 1'b0;
	localparam logic KIND_GRAY = 1'b1;

	// color plane codes
	localparam logic [1:0] COLOR_BLUE  = 2'd0;
	localparam logic [1:0] COLOR_GREEN = 2'd1;
	localparam logic [1:0] COLOR_RED   = 2'd2;

	// classified item handed from the front end to the executor
	typedef struct packed {
		logic       is_scan;
		logic       wr_ok;
		logic       last_pix;
		logic [3:0] row;
		logic [3:0] col;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} item_t;

	// head of the queue as seen by the executor
	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

endpackage

[sv/lmfb_front.sv]
module lmfb_front #(
	parameter int ROWS    = lmfb_pkg::ROWS_DEF,
	parameter int COLUMNS = lmfb_pkg::COLUMNS_DEF
) (
	input  logic                accept,
	input  logic                req_type,
	input  logic [7:0]          pixel_index,
	input  logic [7:0]          red,
	input  logic [7:0]          green,
	input  logic [7:0]          blue,
	input  logic [2:0]          scan_row,
	output logic                push,
	output lmfb_pkg::item_t     item
);

	localparam logic [4:0] ROWS_L = 5'(ROWS);
	localparam logic [5:0] COLS_L = 6'(COLUMNS);

	logic [7:0] idx_sh;
	logic [3:0] wr_row;
	logic [3:0] wr_col;
	logic [9:0] sum;
	logic       over;
	logic       row_ok;
	logic       col_ok;
	logic       scan_ok;

	// split the pixel index and check it against the matrix size
	assign idx_sh  = pixel_index >> lmfb_pkg::INDEX_SHIFT;
	assign wr_row  = idx_sh[3:0];
	assign wr_col  = pixel_index[lmfb_pkg::INDEX_SHIFT-1:0];
	assign row_ok  = {1'b0, wr_row} < ROWS_L;
	assign col_ok  = {2'b00, wr_col} < COLS_L;
	assign scan_ok = {2'b00, scan_row} < ROWS_L;

	// overbright pixels become full blue
	assign sum  = {2'b00, red} + {2'b00, green} + {2'b00, blue};
	assign over = sum > lmfb_pkg::SUM_LIMIT;

	// refresh of a missing row produces nothing and is dropped here
	assign push = accept && ((req_type == lmfb_pkg::REQ_WRITE) || scan_ok);

	always_comb begin
		item = '0;
		if (req_type == lmfb_pkg::REQ_SCAN) begin
			item.is_scan = 1'b1;
			item.row     = {1'b0, scan_row};
		end else begin
			item.is_scan  = 1'b0;
			item.wr_ok    = row_ok && col_ok;
			item.last_pix = ({1'b0, wr_row} == ROWS_L - 5'd1) &&
				({2'b00, wr_col} == COLS_L - 6'd1);
			item.row      = wr_row;
			item.col      = wr_col;
			if (over) begin
				item.red   = 8'd0;
				item.green = 8'd0;
				item.blue  = lmfb_pkg::CHANNEL_MAX;
			end else begin
				item.red   = red;
				item.green = green;
				item.blue  = blue;
			end
		end
	end

endmodule

[sv/lmfb_queue.sv]
module lmfb_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lmfb_pkg::item_t     push_item,
	input  logic                pop,
	output lmfb_pkg::head_t     head,
	output logic                full
);

	localparam int PW = $clog2(lmfb_pkg::QUEUE_DEPTH);
	localparam int CNTW = $clog2(lmfb_pkg::QUEUE_DEPTH + 1);
	localparam logic [CNTW-1:0] DEPTH_C = CNTW'(lmfb_pkg::QUEUE_DEPTH);

	lmfb_pkg::item_t entry_q [lmfb_pkg::QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] count_q;

	assign full       = count_q == DEPTH_C;
	assign head.valid = count_q != '0;
	assign head.item  = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNTW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

endmodule

[sv/lmfb_back.sv]
module lmfb_back #(
	parameter int ROWS      = lmfb_pkg::ROWS_DEF,
	parameter int COLUMNS   = lmfb_pkg::COLUMNS_DEF,
	parameter int GRAY_BITS = lmfb_pkg::GRAY_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lmfb_pkg::head_t     head,
	input  logic                display_enable,
	output logic                pop,
	output logic                clearing,
	output logic                strobe,
	output logic                result_kind,
	output logic                frame_swapped,
	output logic [11:0]         gray_word,
	output logic [1:0]          word_color,
	output logic [3:0]          word_column,
	output logic [2:0]          row_select,
	output logic                row_on,
	output logic                last
);

	localparam int PLANE  = ROWS * COLUMNS;
	localparam int DEPTH  = 2 * PLANE;
	localparam int AW     = $clog2(DEPTH);
	localparam int CW     = $clog2(COLUMNS);
	localparam int GSHIFT = GRAY_BITS - 8;
	localparam logic [AW-1:0] PLANE_A  = AW'(PLANE);
	localparam logic [AW-1:0] COLS_A   = AW'(COLUMNS);
	localparam logic [AW-1:0] LAST_A   = AW'(DEPTH - 1);
	localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_SCAN  = 3'b100
	} back_state_t;

	typedef struct packed {
		logic       kind;
		logic       swapped;
		logic [1:0] color;
		logic [3:0] col;
		logic [2:0] row;
		logic       last;
	} tag_t;

	back_state_t state_q;
	logic [AW-1:0] clr_addr_q;
	logic          front_q;
	logic [3:0]    row_q;
	logic [CW-1:0] col_q;
	logic [1:0]    color_q;
	logic [23:0]   frame_store_q [DEPTH];

	logic          valid_s1;
	tag_t          tag_s1;
	logic [23:0]   rdata_s1;

	logic          strobe_q;
	logic          kind_q;
	logic          swapped_q;
	logic [11:0]   gray_q;
	logic [1:0]    wcolor_q;
	logic [3:0]    column_q;
	logic [2:0]    row_sel_q;
	logic          row_on_q;
	logic          last_q;

	logic          do_write;
	logic          swap;
	logic          scan_last;
	logic [AW-1:0] pix_off;
	logic [AW-1:0] scan_off;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [23:0]   mem_wdata;
	logic [4:0]    col_wide;
	logic [7:0]    sel_byte;
	logic [15:0]   gray_wide;

	// dispatch from the queue head
	assign clearing  = state_q == ST_CLEAR;
	assign pop       = (state_q == ST_IDLE) && head.valid;
	assign do_write  = pop && !head.item.is_scan && head.item.wr_ok;
	assign swap      = do_write && head.item.last_pix;
	assign scan_last = (color_q == lmfb_pkg::COLOR_RED) && (col_q == COL_LAST);

	// addresses: writes go to the back buffer, scans read the front one
	assign pix_off  = AW'(head.item.row) * COLS_A + AW'(head.item.col);
	assign scan_off = AW'(row_q) * COLS_A + AW'(col_q);
	assign wr_addr  = (front_q ? '0 : PLANE_A) + pix_off;
	assign rd_addr  = (front_q ? PLANE_A : '0) + scan_off;

	// single write port shared by the clearing pass and pixel writes
	always_comb begin
		if (clearing) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = (clr_addr_q < PLANE_A) ? 24'd0 : {3{lmfb_pkg::BACK_FILL}};
		end else begin
			mem_we    = do_write;
			mem_waddr = wr_addr;
			mem_wdata = {head.item.red, head.item.green, head.item.blue};
		end
	end

	// frame store, blue in the low byte
	always_ff @(posedge clk) begin
		if (mem_we) begin
			frame_store_q[mem_waddr] <= mem_wdata;
		end
		rdata_s1 <= frame_store_q[rd_addr];
	end

	// sequencer: clearing pass, dispatch, row scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			front_q    <= 1'b0;
			row_q      <= '0;
			col_q      <= '0;
			color_q    <= lmfb_pkg::COLOR_BLUE;
			valid_s1   <= 1'b0;
		end else begin
			valid_s1 <= (pop && !head.item.is_scan) || (state_q == ST_SCAN);
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == LAST_A) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop && head.item.is_scan) begin
						row_q   <= head.item.row;
						col_q   <= '0;
						color_q <= lmfb_pkg::COLOR_BLUE;
						state_q <= ST_SCAN;
					end else if (swap) begin
						front_q <= ~front_q;
					end
				end
				ST_SCAN: begin
					if (scan_last) begin
						state_q <= ST_IDLE;
					end else if (col_q == COL_LAST) begin
						col_q   <= '0;
						color_q <= color_q + 2'd1;
					end else begin
						col_q <= col_q + CW'(1);
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// tag travelling alongside the memory read
	assign col_wide = 5'(col_q);

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) begin
			tag_s1.kind    <= lmfb_pkg::KIND_GRAY;
			tag_s1.swapped <= 1'b0;
			tag_s1.color   <= color_q;
			tag_s1.col     <= col_wide[3:0];
			tag_s1.row     <= row_q[2:0];
			tag_s1.last    <= scan_last;
		end else begin
			tag_s1.kind    <= lmfb_pkg::KIND_ACK;
			tag_s1.swapped <= swap;
			tag_s1.color   <= lmfb_pkg::COLOR_BLUE;
			tag_s1.col     <= 4'd0;
			tag_s1.row     <= 3'd0;
			tag_s1.last    <= 1'b1;
		end
	end

	// pick the color byte and scale it to the grayscale width
	always_comb begin
		case (tag_s1.color)
			lmfb_pkg::COLOR_BLUE:  sel_byte = rdata_s1[7:0];
			lmfb_pkg::COLOR_GREEN: sel_byte = rdata_s1[15:8];
			lmfb_pkg::COLOR_RED:   sel_byte = rdata_s1[23:16];
			default:               sel_byte = 8'd0;
		endcase
	end

	assign gray_wide = {8'h00, sel_byte} << GSHIFT;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		kind_q    <= tag_s1.kind;
		swapped_q <= tag_s1.swapped;
		gray_q    <= (tag_s1.kind == lmfb_pkg::KIND_GRAY) ? gray_wide[11:0] : 12'd0;
		wcolor_q  <= tag_s1.color;
		column_q  <= tag_s1.col;
		row_sel_q <= tag_s1.row;
		row_on_q  <= (tag_s1.kind == lmfb_pkg::KIND_GRAY) ? display_enable : 1'b0;
		last_q    <= tag_s1.last;
	end

	assign strobe        = strobe_q;
	assign result_kind   = kind_q;
	assign frame_swapped = swapped_q;
	assign gray_word     = gray_q;
	assign word_color    = wcolor_q;
	assign word_column   = column_q;
	assign row_select    = row_sel_q;
	assign row_on        = row_on_q;
	assign last          = last_q;

endmodule

[sv/led_matrix_frame_buffer_scan.sv]
// Double-buffered RGB LED matrix frame store with row scan-out.
// Input: an item is taken on a clock edge with start high and busy low.
// req_type 0 writes one pixel (pixel_index, red, green, blue) into the back
// buffer; a write to the last pixel swaps front and back. req_type 1 asks
// for the grayscale words of scan_row from the front buffer.
// Output: every result is shown for one cycle with strobe high; the
// receiver cannot stall, so no result is ever held back. A write gives one
// acknowledge; a refresh gives 3*COLUMNS words (48 by default) on consecutive
// cycles, and a refresh of a row past the last gives nothing.
// Throughput: writes sustain one per cycle while not busy; a refresh holds
// the executor for the row, one frame store read per word. A two-entry queue
// sits between the front end and the executor; busy rises when it is full.
// Reset: the frame store is initialized by a pass over its 2*ROWS*COLUMNS
// pixels (256 by default), one pixel per cycle, with busy held high. The
// display_enable register (cfg_wr_en, cfg_wr_data) clears to 0 and may be
// written at any time, also during that pass.
module led_matrix_frame_buffer_scan #(
	parameter int ROWS      = lmfb_pkg::ROWS_DEF,
	parameter int COLUMNS   = lmfb_pkg::COLUMNS_DEF,
	parameter int GRAY_BITS = lmfb_pkg::GRAY_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [7:0]  pixel_index,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [2:0]  scan_row,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	output logic        strobe,
	output logic        result_kind,
	output logic        frame_swapped,
	output logic [11:0] gray_word,
	output logic [1:0]  word_color,
	output logic [3:0]  word_column,
	output logic [2:0]  row_select,
	output logic        row_on,
	output logic        last
);

	logic            display_enable_q;
	logic            accept;
	logic            push;
	logic            pop;
	logic            full;
	logic            clearing;
	lmfb_pkg::item_t push_item;
	lmfb_pkg::head_t head;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_enable_q <= 1'b0;
		end else if (cfg_wr_en) begin
			display_enable_q <= cfg_wr_data;
		end
	end

	// input handshake
	assign busy   = clearing || full;
	assign accept = start && !busy;

	lmfb_front #(
		.ROWS    (ROWS),
		.COLUMNS (COLUMNS)
	) u_front (
		.accept      (accept),
		.req_type    (req_type),
		.pixel_index (pixel_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.scan_row    (scan_row),
		.push        (push),
		.item        (push_item)
	);

	lmfb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.full      (full)
	);

	lmfb_back #(
		.ROWS      (ROWS),
		.COLUMNS   (COLUMNS),
		.GRAY_BITS (GRAY_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.display_enable (display_enable_q),
		.pop            (pop),
		.clearing       (clearing),
		.strobe         (strobe),
		.result_kind    (result_kind),
		.frame_swapped  (frame_swapped),
		.gray_word      (gray_word),
		.word_color     (word_color),
		.word_column    (word_column),
		.row_select     (row_select),
		.row_on         (row_on),
		.last           (last)
	);

endmodule

[sv/lmfb_checker.sv]
module lmfb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       strobe,
	input logic       result_kind,
	input logic       frame_swapped,
	input logic [1:0] word_color,
	input logic [2:0] row_select,
	input logic       last
);

	// every write acknowledge closes its item
	a_ack_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (result_kind == lmfb_pkg::KIND_ACK) |-> last)
		else $error("write acknowledge without last");

	// a swap is only reported on an acknowledge
	a_swap_ack: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && frame_swapped |-> (result_kind == lmfb_pkg::KIND_ACK))
		else $error("frame swap flagged on a grayscale word");

	// a row ends with the red plane
	a_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (result_kind == lmfb_pkg::KIND_GRAY) && last |->
		(word_color == lmfb_pkg::COLOR_RED))
		else $error("row scan ended outside the red plane");

	// a row streams without gaps and keeps its row address
	a_row_stream: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (result_kind == lmfb_pkg::KIND_GRAY) && !last |=>
		strobe && (result_kind == lmfb_pkg::KIND_GRAY) &&
		(row_select == $past(row_select)))
		else $error("row scan interrupted or changed row");

endmodule

bind led_matrix_frame_buffer_scan lmfb_checker u_lmfb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.strobe        (strobe),
	.result_kind   (result_kind),
	.frame_swapped (frame_swapped),
	.word_color    (word_color),
	.row_select    (row_select),
	.last          (last)
);
